@@ hw/rtl/wffs_pkg.sv @@
// ----------------------------------------------------------------------------
// wffs_pkg
// shared widths, limits, register codes and the per-sample feature word
// ----------------------------------------------------------------------------
`default_nettype none

package wffs_pkg;

	localparam int MAX_SAMPLES = 4096;
	localparam int HIST_DEPTH  = 1024;
	localparam int IDX_W       = $clog2(MAX_SAMPLES);
	localparam int HIST_AW     = $clog2(HIST_DEPTH);

	localparam int ALPHA_W = 16;
	localparam int LAG_W   = 10;
	localparam int RAW_W   = 16;
	localparam int SUB_W   = 18;
	localparam int LP_W    = 26;
	localparam int HP_W    = 27;
	localparam int DIFF_W  = 27;
	localparam int SUM_W   = 30;

	localparam int IN_DATA_W  = 40;
	localparam int OUT_DATA_W = 232;
	localparam int CFG_IDX_W  = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_LP_ALPHA = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HP_ALPHA = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DIFF_LAG = 2'd2;

	localparam logic [ALPHA_W-1:0] LP_ALPHA_RST = 16'd6554;
	localparam logic [ALPHA_W-1:0] HP_ALPHA_RST = 16'd58982;
	localparam logic [LAG_W-1:0]   DIFF_LAG_RST = 10'd4;

	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_SAMPLES - 1);

	localparam logic signed [LP_W-1:0]  LP_MAX  = {1'b0, {(LP_W-1){1'b1}}};
	localparam logic signed [LP_W-1:0]  LP_MIN  = {1'b1, {(LP_W-1){1'b0}}};
	localparam logic signed [HP_W-1:0]  HP_MAX  = {1'b0, {(HP_W-1){1'b1}}};
	localparam logic signed [HP_W-1:0]  HP_MIN  = {1'b1, {(HP_W-1){1'b0}}};
	localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

	typedef struct packed {
		logic signed [LP_W-1:0]  lowpass;
		logic signed [HP_W-1:0]  highpass;
		logic signed [SUM_W-1:0] running_sum;
		logic signed [RAW_W-1:0] raw_peak;
		logic [IDX_W-1:0]        raw_peak_at;
		logic signed [RAW_W-1:0] raw_trough;
		logic [IDX_W-1:0]        raw_trough_at;
		logic signed [SUB_W-1:0] sub_peak;
		logic [IDX_W-1:0]        sub_peak_at;
		logic signed [SUB_W-1:0] sub_trough;
		logic [IDX_W-1:0]        sub_trough_at;
		logic [IDX_W-1:0]        idx;
	} feat_t;

endpackage

`default_nettype wire

@@ hw/rtl/waveform_filter_feature_stream.sv @@
// ----------------------------------------------------------------------------
// waveform_filter_feature_stream
// rc low-pass / high-pass, lag difference, running sum and extremes per sample
// ----------------------------------------------------------------------------
// samples enter on the s_axis channel: raw and baselined sample in tdata,
// the end of a waveform on tlast. every accepted word gives exactly one
// feature word on m_axis, in order.
// the pipeline has three registers: input, filter state plus history read,
// and the output register, which drives m_axis; an accepted word passes
// through them in that order.
// one word per cycle is taken and given while m_tready stays high; the filter
// recurrences close combinationally around their state, one multiply per filter.
// when m_tready is low, the stages behind the output fill up and s_tready
// drops only once every stage holds a word.
// the lag difference reads a 1024-entry low-pass history memory with one
// write and one registered read per cycle; it needs no clearing after reset.
// reset empties the pipeline, restarts the waveform at index 0 and loads
// the default alphas and lag. the cfg channel is always ready; the user must
// write it only while no sample is in flight, the block does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module waveform_filter_feature_stream (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	// raw_sample[15:0], baselined_sample[33:16], zero fill
	input  wire logic [wffs_pkg::IN_DATA_W-1:0]      s_tdata,
	input  wire logic                                s_tlast,
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	// lowpass_out[25:0], highpass_out[52:26], lag_difference[79:53],
	// running_sum[109:80], raw_peak[125:110], raw_peak_at[137:126],
	// raw_trough[153:138], raw_trough_at[165:154], sub_peak[183:166],
	// sub_peak_at[195:184], sub_trough[213:196], sub_trough_at[225:214], zero fill
	output logic [wffs_pkg::OUT_DATA_W-1:0]          m_tdata,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [wffs_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [wffs_pkg::ALPHA_W-1:0]        cfg_data
);
	import wffs_pkg::*;

	logic [ALPHA_W-1:0] lp_alpha_q, hp_alpha_q;
	logic [LAG_W-1:0]   lag_q;

	logic                    valid_s1;
	logic signed [RAW_W-1:0] raw_s1;
	logic signed [SUB_W-1:0] sub_s1;
	logic                    last_s1;

	logic                    valid_s2;
	feat_t                   feat_s2;
	logic signed [LP_W-1:0]  hist_s2;

	logic                    out_valid_q;
	logic [OUT_DATA_W-1:0]   out_q;

	logic                    en1, en2, en3, step;
	feat_t                   feat;
	logic [IDX_W-1:0]        lag_eff;
	logic [HIST_AW-1:0]      rd_addr;
	logic signed [DIFF_W-1:0] diff;

	logic signed [LP_W-1:0]  hist_mem [HIST_DEPTH];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lp_alpha_q <= LP_ALPHA_RST;
			hp_alpha_q <= HP_ALPHA_RST;
			lag_q      <= DIFF_LAG_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_LP_ALPHA: lp_alpha_q <= cfg_data;
				CFG_HP_ALPHA: hp_alpha_q <= cfg_data;
				CFG_DIFF_LAG: lag_q <= cfg_data[LAG_W-1:0];
				default: ;
			endcase
		end
	end

	// per-stage enables let bubbles close up behind a stalled output
	assign en3      = !out_valid_q || m_tready;
	assign en2      = !valid_s2 || en3;
	assign en1      = !valid_s1 || en2;
	assign s_tready = en1;
	assign step     = valid_s1 && en2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (en1) begin
				valid_s1 <= s_tvalid;
			end
			if (en2) begin
				valid_s2 <= valid_s1;
			end
			if (en3) begin
				out_valid_q <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			raw_s1  <= $signed(s_tdata[RAW_W-1:0]);
			sub_s1  <= $signed(s_tdata[RAW_W+SUB_W-1:RAW_W]);
			last_s1 <= s_tlast;
		end
		if (en2) begin
			feat_s2 <= feat;
		end
	end

	wffs_core u_core (
		.clk              (clk),
		.arst_n           (arst_n),
		.step             (step),
		.raw_sample       (raw_s1),
		.baselined_sample (sub_s1),
		.last_sample      (last_s1),
		.lowpass_alpha    (lp_alpha_q),
		.highpass_alpha   (hp_alpha_q),
		.feat             (feat)
	);

	// lag is limited to what the history holds
	assign lag_eff = (32'(lag_q) > HIST_DEPTH - 1) ? IDX_W'(HIST_DEPTH - 1) : IDX_W'(lag_q);
	assign rd_addr = HIST_AW'(feat.idx - lag_eff);

	// the entry read for a sample was written at least one word earlier
	always_ff @(posedge clk) begin
		if (step) begin
			hist_mem[HIST_AW'(feat.idx)] <= feat.lowpass;
		end
		if (en2) begin
			hist_s2 <= hist_mem[rd_addr];
		end
	end

	always_comb begin
		if (lag_eff != '0 && feat_s2.idx > lag_eff) begin
			diff = DIFF_W'(feat_s2.lowpass) - DIFF_W'(hist_s2);
		end else begin
			diff = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			out_q <= {6'd0,
				feat_s2.sub_trough_at, feat_s2.sub_trough,
				feat_s2.sub_peak_at, feat_s2.sub_peak,
				feat_s2.raw_trough_at, feat_s2.raw_trough,
				feat_s2.raw_peak_at, feat_s2.raw_peak,
				feat_s2.running_sum, diff,
				feat_s2.highpass, feat_s2.lowpass};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

endmodule

`default_nettype wire

@@ hw/rtl/wffs_core.sv @@
// ----------------------------------------------------------------------------
// wffs_core
// per-sample filter recurrences, running sum, extremes and waveform index
// ----------------------------------------------------------------------------
`default_nettype none

module wffs_core (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           step,
	input  wire logic signed [wffs_pkg::RAW_W-1:0] raw_sample,
	input  wire logic signed [wffs_pkg::SUB_W-1:0] baselined_sample,
	input  wire logic                           last_sample,
	input  wire logic [wffs_pkg::ALPHA_W-1:0]   lowpass_alpha,
	input  wire logic [wffs_pkg::ALPHA_W-1:0]   highpass_alpha,
	output wffs_pkg::feat_t                     feat
);
	import wffs_pkg::*;

	logic [IDX_W-1:0]        idx_q;
	logic signed [LP_W-1:0]  lp_q;
	logic signed [HP_W-1:0]  hp_q;
	logic signed [SUB_W-1:0] prev_q;
	logic signed [SUM_W-1:0] sum_q;
	logic signed [RAW_W-1:0] raw_pk_q, raw_tr_q;
	logic [IDX_W-1:0]        raw_pk_at_q, raw_tr_at_q;
	logic signed [SUB_W-1:0] sub_pk_q, sub_tr_q;
	logic [IDX_W-1:0]        sub_pk_at_q, sub_tr_at_q;

	logic                    first;
	logic signed [LP_W-1:0]  x;
	logic signed [LP_W:0]    lp_d;
	logic signed [43:0]      lp_p;
	logic signed [27:0]      lp_r;
	logic signed [28:0]      lp_n;
	logic signed [LP_W-1:0]  lp_sat;
	logic signed [28:0]      hp_h;
	logic signed [45:0]      hp_p;
	logic signed [29:0]      hp_r;
	logic signed [HP_W-1:0]  hp_sat;
	logic signed [SUM_W:0]   sum_n;
	logic signed [SUM_W-1:0] sum_sat;
	logic                    raw_up, raw_dn, sub_up, sub_dn;

	assign first = (idx_q == '0);
	assign x     = $signed({baselined_sample, 8'd0});

	// low-pass: y + round(a * (x - y))
	assign lp_d = (LP_W+1)'(x) - (LP_W+1)'(lp_q);
	assign lp_p = 44'($signed({1'b0, lowpass_alpha})) * 44'(lp_d);
	assign lp_r = 28'((lp_p + 44'sd32768) >>> 16);
	assign lp_n = 29'(lp_q) + 29'(lp_r);

	always_comb begin
		if (lp_n > 29'(LP_MAX)) begin
			lp_sat = LP_MAX;
		end else if (lp_n < 29'(LP_MIN)) begin
			lp_sat = LP_MIN;
		end else begin
			lp_sat = LP_W'(lp_n);
		end
	end

	// high-pass: round(a * (h + x - x_prev))
	assign hp_h = 29'(hp_q) + 29'(x) - 29'($signed({prev_q, 8'd0}));
	assign hp_p = 46'($signed({1'b0, highpass_alpha})) * 46'(hp_h);
	assign hp_r = 30'((hp_p + 46'sd32768) >>> 16);

	always_comb begin
		if (hp_r > 30'(HP_MAX)) begin
			hp_sat = HP_MAX;
		end else if (hp_r < 30'(HP_MIN)) begin
			hp_sat = HP_MIN;
		end else begin
			hp_sat = HP_W'(hp_r);
		end
	end

	assign sum_n = (SUM_W+1)'(sum_q) + (SUM_W+1)'(baselined_sample);

	always_comb begin
		if (sum_n > (SUM_W+1)'(SUM_MAX)) begin
			sum_sat = SUM_MAX;
		end else if (sum_n < (SUM_W+1)'(SUM_MIN)) begin
			sum_sat = SUM_MIN;
		end else begin
			sum_sat = SUM_W'(sum_n);
		end
	end

	// strict compares keep the first occurrence
	assign raw_up = first || (raw_sample > raw_pk_q);
	assign raw_dn = first || (raw_sample < raw_tr_q);
	assign sub_up = first || (baselined_sample > sub_pk_q);
	assign sub_dn = first || (baselined_sample < sub_tr_q);

	always_comb begin
		feat.lowpass       = first ? x : lp_sat;
		feat.highpass      = first ? HP_W'(x) : hp_sat;
		feat.running_sum   = first ? SUM_W'(baselined_sample) : sum_sat;
		feat.raw_peak      = raw_up ? raw_sample : raw_pk_q;
		feat.raw_peak_at   = raw_up ? idx_q : raw_pk_at_q;
		feat.raw_trough    = raw_dn ? raw_sample : raw_tr_q;
		feat.raw_trough_at = raw_dn ? idx_q : raw_tr_at_q;
		feat.sub_peak      = sub_up ? baselined_sample : sub_pk_q;
		feat.sub_peak_at   = sub_up ? idx_q : sub_pk_at_q;
		feat.sub_trough    = sub_dn ? baselined_sample : sub_tr_q;
		feat.sub_trough_at = sub_dn ? idx_q : sub_tr_at_q;
		feat.idx           = idx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (step) begin
			if (last_sample || idx_q == IDX_LAST) begin
				idx_q <= '0;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	// waveform state, overwritten by the first sample of each waveform
	always_ff @(posedge clk) begin
		if (step) begin
			lp_q        <= feat.lowpass;
			hp_q        <= feat.highpass;
			prev_q      <= baselined_sample;
			sum_q       <= feat.running_sum;
			raw_pk_q    <= feat.raw_peak;
			raw_pk_at_q <= feat.raw_peak_at;
			raw_tr_q    <= feat.raw_trough;
			raw_tr_at_q <= feat.raw_trough_at;
			sub_pk_q    <= feat.sub_peak;
			sub_pk_at_q <= feat.sub_peak_at;
			sub_tr_q    <= feat.sub_trough;
			sub_tr_at_q <= feat.sub_trough_at;
		end
	end

endmodule

`default_nettype wire
